// ===== rtl/vpa_pkg.sv =====
// Shared types and constants of the variable partition allocator.
package vpa_pkg;

  localparam int unsigned SIZE_W  = 21;
  localparam int unsigned RBASE_W = 20;
  localparam int unsigned OWNER_W = 16;

  // Item kinds.
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  // Fit policies.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration register indexes.
  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_MEMORY_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOOWNER = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_ALLOC,
    OP_FREE,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_NEXT,
    S_MERGE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  request_size;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic               has_region;
    logic [RBASE_W-1:0] region_base;
    logic [SIZE_W-1:0]  region_size;
  } out_item_t;

  typedef struct packed {
    op_e                op;
    logic               req_zero;
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0]  req;
  } cmd_t;

endpackage

// ===== rtl/vpa_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine.
module vpa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  vpa_pkg::in_item_t in_data_i,
  output logic              cmd_valid_o,
  output vpa_pkg::cmd_t     cmd_o,
  input  logic              cmd_pop_i
);
  import vpa_pkg::*;

  cmd_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       do_push, do_pop;

  // Classify the incoming item.
  always_comb begin
    case (in_data_i.kind)
      KIND_INIT:  cls.op = OP_INIT;
      KIND_ALLOC: cls.op = OP_ALLOC;
      KIND_FREE:  cls.op = OP_FREE;
      default:    cls.op = OP_NONE;
    endcase
    cls.req_zero = (in_data_i.request_size == '0);
    cls.owner    = in_data_i.owner_id;
    cls.req      = in_data_i.request_size;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/vpa_engine.sv =====
// Back end: partition table and the sequencer that scans, splits and merges it.
module vpa_engine #(
  parameter int unsigned MAX_PARTS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  vpa_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  input  logic [1:0]                 fit_policy_i,
  input  logic [vpa_pkg::SIZE_W-1:0] memory_size_i,
  output logic                       res_valid_o,
  output vpa_pkg::out_item_t         res_o,
  input  logic                       res_pop_i
);
  import vpa_pkg::*;

  localparam int unsigned IW = $clog2(MAX_PARTS);
  localparam int unsigned CW = $clog2(MAX_PARTS + 1);
  localparam longint unsigned LIMIT = longint'(1) << RBASE_W;

  // Partition table.
  logic [RBASE_W-1:0]   base_q  [MAX_PARTS];
  logic [SIZE_W-1:0]    size_q  [MAX_PARTS];
  logic [OWNER_W-1:0]   owner_q [MAX_PARTS];
  logic                 used_q  [MAX_PARTS];
  logic [CW-1:0]        count_q;

  state_e               state_q, state_d;
  cmd_t                 cmd_q;
  logic [IW-1:0]        idx_q, pick_q;
  logic                 found_q;
  logic [RBASE_W-1:0]   pbase_q;
  logic [SIZE_W-1:0]    psize_q;
  logic                 prev_free_q, lf_q, rf_q;
  logic [SIZE_W-1:0]    prev_size_q, lsize_q, rsize_q;
  out_item_t            pend_q, res_q;
  logic                 res_valid_q;

  logic [RBASE_W-1:0]   rd_base;
  logic [SIZE_W-1:0]    rd_size;
  logic [OWNER_W-1:0]   rd_owner;
  logic                 rd_used;
  logic                 last, cand, better, pol_first, hit, has_next;
  logic [SIZE_W-1:0]    rest, new_size;
  logic [SIZE_W-1:0]    init_size;
  logic                 load_res;

  // Single scan read port.
  assign rd_base  = base_q[idx_q];
  assign rd_size  = size_q[idx_q];
  assign rd_owner = owner_q[idx_q];
  assign rd_used  = used_q[idx_q];

  assign last      = (CW'(idx_q) + CW'(1)) == count_q;
  assign has_next  = (CW'(idx_q) + CW'(1)) < count_q;
  assign pol_first = (fit_policy_i != FIT_BEST) && (fit_policy_i != FIT_WORST);
  assign cand      = !rd_used && (rd_size >= cmd_q.req);
  assign hit       = rd_used && (rd_owner == cmd_q.owner);
  assign rest      = psize_q - cmd_q.req;
  assign new_size  = psize_q + (rf_q ? rsize_q : '0);
  assign init_size = ({43'd0, memory_size_i} > 64'(LIMIT)) ? SIZE_W'(LIMIT) : memory_size_i;
  assign load_res  = (state_q == S_RESP) && (!res_valid_q || res_pop_i);

  always_comb begin
    case (fit_policy_i)
      FIT_BEST:  better = !found_q || (rd_size <= psize_q);
      FIT_WORST: better = !found_q || (rd_size >= psize_q);
      default:   better = !found_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == OP_ALLOC || cmd_i.op == OP_FREE) ? S_SCAN : S_RESP;
        end
      end
      S_SCAN: begin
        if (cmd_q.op == OP_ALLOC) begin
          if ((cand && pol_first) || last) state_d = S_DECIDE;
        end else if (hit) begin
          state_d = has_next ? S_NEXT : S_MERGE;
        end else if (last) begin
          state_d = S_RESP;
        end
      end
      S_DECIDE: state_d = S_RESP;
      S_NEXT:   state_d = S_MERGE;
      S_MERGE:  state_d = S_RESP;
      S_RESP:   if (load_res) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
    res_valid_o = res_valid_q;
    res_o       = res_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_res)               res_valid_q <= 1'b1;
      else if (res_pop_i)         res_valid_q <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (load_res) res_q <= pend_q;
  end

  // Sequencer datapath.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q       <= cmd_i;
        idx_q       <= '0;
        found_q     <= 1'b0;
        prev_free_q <= 1'b0;
        pend_q      <= '{status: ST_OK, has_region: 1'b0, region_base: '0, region_size: '0};
      end
      S_SCAN: begin
        if (cmd_q.op == OP_ALLOC) begin
          if (cand && better) begin
            found_q <= 1'b1;
            pick_q  <= idx_q;
            pbase_q <= rd_base;
            psize_q <= rd_size;
          end
          if (!last) idx_q <= idx_q + IW'(1);
        end else if (hit) begin
          pick_q  <= idx_q;
          pbase_q <= rd_base;
          psize_q <= rd_size;
          lf_q    <= (idx_q != '0) && prev_free_q;
          lsize_q <= prev_size_q;
          rf_q    <= 1'b0;
          if (has_next) idx_q <= idx_q + IW'(1);
        end else begin
          prev_free_q <= !rd_used;
          prev_size_q <= rd_size;
          if (last) pend_q.status <= ST_NOOWNER;
          else      idx_q <= idx_q + IW'(1);
        end
      end
      S_NEXT: begin
        rf_q    <= !rd_used;
        rsize_q <= rd_size;
      end
      S_DECIDE: begin
        if (!found_q) begin
          pend_q.status <= ST_NOSPACE;
        end else if (cmd_q.req_zero) begin
          pend_q.status <= ST_OK;
        end else if (rest != '0 && count_q == CW'(MAX_PARTS)) begin
          pend_q.status <= ST_FULL;
        end else begin
          pend_q <= '{status: ST_OK, has_region: 1'b1,
                      region_base: pbase_q, region_size: cmd_q.req};
        end
      end
      S_MERGE: begin
        pend_q <= '{status: ST_OK, has_region: 1'b1,
                    region_base: pbase_q, region_size: psize_q};
      end
      default: ;
    endcase
  end

  // Table updates: init, split with a right shift, release with a left shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(MAX_PARTS); k++) begin
        base_q[k]  <= '0;
        size_q[k]  <= '0;
        owner_q[k] <= '0;
        used_q[k]  <= 1'b0;
      end
      size_q[0] <= SIZE_W'(4096);
      count_q   <= CW'(1);
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_i.op == OP_INIT) begin
            base_q[0]  <= '0;
            size_q[0]  <= init_size;
            owner_q[0] <= '0;
            used_q[0]  <= 1'b0;
            count_q    <= CW'(1);
          end
        end
        S_DECIDE: begin
          if (found_q && !cmd_q.req_zero) begin
            if (rest == '0) begin
              used_q[pick_q]  <= 1'b1;
              owner_q[pick_q] <= cmd_q.owner;
            end else if (count_q != CW'(MAX_PARTS)) begin
              for (int k = 1; k < int'(MAX_PARTS); k++) begin
                if (k > int'(pick_q) + 1) begin
                  base_q[k]  <= base_q[k-1];
                  size_q[k]  <= size_q[k-1];
                  owner_q[k] <= owner_q[k-1];
                  used_q[k]  <= used_q[k-1];
                end
              end
              size_q[pick_q]           <= cmd_q.req;
              owner_q[pick_q]          <= cmd_q.owner;
              used_q[pick_q]           <= 1'b1;
              base_q[pick_q + IW'(1)]  <= RBASE_W'(pbase_q + RBASE_W'(cmd_q.req));
              size_q[pick_q + IW'(1)]  <= rest;
              owner_q[pick_q + IW'(1)] <= '0;
              used_q[pick_q + IW'(1)]  <= 1'b0;
              count_q                  <= count_q + CW'(1);
            end
          end
        end
        S_MERGE: begin
          // Close the gap left by the absorbed entries.
          if (lf_q || rf_q) begin
            for (int k = 0; k < int'(MAX_PARTS); k++) begin
              if (k >= int'(pick_q) + (lf_q ? 0 : 1)) begin
                if (lf_q && rf_q) begin
                  if (k + 2 < int'(MAX_PARTS)) begin
                    base_q[k]  <= base_q[k+2];
                    size_q[k]  <= size_q[k+2];
                    owner_q[k] <= owner_q[k+2];
                    used_q[k]  <= used_q[k+2];
                  end
                end else if (k + 1 < int'(MAX_PARTS)) begin
                  base_q[k]  <= base_q[k+1];
                  size_q[k]  <= size_q[k+1];
                  owner_q[k] <= owner_q[k+1];
                  used_q[k]  <= used_q[k+1];
                end
              end
            end
          end
          if (lf_q) begin
            size_q[pick_q - IW'(1)] <= lsize_q + new_size;
            count_q <= count_q - (rf_q ? CW'(2) : CW'(1));
          end else begin
            size_q[pick_q]  <= new_size;
            used_q[pick_q]  <= 1'b0;
            owner_q[pick_q] <= '0;
            if (rf_q) count_q <= count_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/variable_partition_allocator.sv =====
// Variable partition allocator: top level with configuration registers.
//
// Items enter through a queue-like port: an item is taken when push is high
// and full is low. Kind 0 rebuilds the table as one free partition of
// memory_size bytes, at most 2^20, kind 1 allocates by first, best or worst fit,
// kind 2 releases the owner's lowest-based partition and merges free neighbours.
// Each item gives one result, shown while empty is low and taken with pop.
// A two-entry front queue takes new items while the engine works and while
// a result waits, so a stalled receiver only stops intake once both fill.
// Init and unknown kinds go straight to the result; an allocate or free
// scans the table one entry a cycle through a single read port, and a split
// or merge then shifts the whole table at once in its decide or merge state.
// Configuration is an APB-style port: fit_policy at address 0, memory_size
// at address 4; memory_size is used at the next init item.
// Reset leaves one free partition of 4096 bytes, first fit, both queues empty.
module variable_partition_allocator #(
  parameter int unsigned MAX_PARTS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  vpa_pkg::in_item_t  in_data_i,
  output logic               empty,
  input  logic               pop,
  output vpa_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import vpa_pkg::*;

  logic              cmd_valid, cmd_pop, res_valid;
  cmd_t              cmd;
  logic [1:0]        fit_policy_q;
  logic [SIZE_W-1:0] memory_size_q;
  logic              cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q  <= FIT_FIRST;
      memory_size_q <= SIZE_W'(4096);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIT_POLICY) fit_policy_q  <= pwdata[1:0];
      else                            memory_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_FIT_POLICY) prdata = {30'd0, fit_policy_q};
    else                            prdata = {11'd0, memory_size_q};
  end

  vpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  vpa_engine #(
    .MAX_PARTS (MAX_PARTS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .fit_policy_i  (fit_policy_q),
    .memory_size_i (memory_size_q),
    .res_valid_o   (res_valid),
    .res_o         (out_data_o),
    .res_pop_i     (pop)
  );

  assign empty = !res_valid;

  // A granted or released region always comes with status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.has_region) |-> (out_data_o.status == ST_OK))
    else $error("region reported with a failing status");

  // Without a region the base and size read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.has_region) |->
      (out_data_o.region_base == '0 && out_data_o.region_size == '0))
    else $error("stale region fields on a result without a region");

  // The front queue only reports full while it holds items for the engine.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> cmd_valid)
    else $error("front queue full but empty");

endmodule
